// ===== sv/tx_block_stream_parser_core_macros.svh =====
// Assertion macros for the transaction/block stream parser.
// No dependencies; included by modules that carry assertions.
`ifndef TX_BLOCK_STREAM_PARSER_CORE_MACROS_SVH
`define TX_BLOCK_STREAM_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TBSP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TBSP_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TBSP_ASSERT(label, clk, rst_n, prop)
`define TBSP_ASSERT_R(label, clk, prop)
`endif
`endif

// ===== sv/tbsp_pkg.sv =====
// Shared types and constants of the transaction/block stream parser.
// No dependencies.
package tbsp_pkg;

  localparam logic [4:0] TAG_VERSION   = 5'd0;
  localparam logic [4:0] TAG_TXCOUNT   = 5'd6;
  localparam logic [4:0] TAG_TXVERSION = 5'd7;
  localparam logic [4:0] TAG_INCOUNT   = 5'd8;
  localparam logic [4:0] TAG_PREVHASH  = 5'd9;
  localparam logic [4:0] TAG_INSCRLEN  = 5'd11;
  localparam logic [4:0] TAG_INSCRIPT  = 5'd12;
  localparam logic [4:0] TAG_SEQUENCE  = 5'd13;
  localparam logic [4:0] TAG_OUTCOUNT  = 5'd14;
  localparam logic [4:0] TAG_OUTVALUE  = 5'd15;
  localparam logic [4:0] TAG_OUTSCRLEN = 5'd16;
  localparam logic [4:0] TAG_OUTSCRIPT = 5'd17;
  localparam logic [4:0] TAG_LOCKTIME  = 5'd18;
  localparam logic [4:0] TAG_IDLE      = 5'd19;

  localparam logic [2:0] ST_PARSING   = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_COUNT_BIG = 3'd2;
  localparam logic [2:0] ST_SCRIPT    = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_TRAIL     = 3'd5;
  localparam logic [2:0] ST_IGNORED   = 3'd6;

  typedef enum logic [1:0] {KIND_FIX, KIND_VAR, KIND_SCR} kind_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [7:0]  byte_out;
    logic        field_end;
    logic [63:0] field_value;
    logic [23:0] tx_number;
    logic [23:0] entry_number;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [7:0]  byte_in;
    logic [23:0] bytes_after;
    logic        first_byte;
  } item_t;

  function automatic logic [5:0] field_len(input logic [4:0] tag);
    unique case (tag)
      5'd1, 5'd2, 5'd9: field_len = 6'd32;
      5'd15:            field_len = 6'd8;
      default:          field_len = 6'd4;
    endcase
  endfunction

  function automatic kind_t field_kind(input logic [4:0] tag);
    unique case (tag)
      TAG_TXCOUNT, TAG_INCOUNT, TAG_INSCRLEN, TAG_OUTCOUNT, TAG_OUTSCRLEN:
        field_kind = KIND_VAR;
      TAG_INSCRIPT, TAG_OUTSCRIPT: field_kind = KIND_SCR;
      default: field_kind = KIND_FIX;
    endcase
  endfunction

endpackage

// ===== sv/tx_block_stream_parser_core.sv =====
// Top level of the transaction/block stream parser.
// Depends on tbsp_pkg, tbsp_seq (with tbsp_field) and the assertion macros.
//
// Byte-serial parser for one transaction or, with parse_mode set, a whole block
// (80-byte header, compact-size transaction count, transactions). One byte is a
// transfer on the in_ channel and yields exactly one result transfer on out_.
// Throughput is one byte per clock while out_ is not stalled: all parsing for a
// byte sits between the input handshake and the output register, and a second
// output slot keeps in_tready high while one result waits. Results are registered
// in the output queue. Count checks compare count*k against bytes_after with a
// small constant multiply. parse_mode is sampled at each byte flagged first_byte.
`include "tx_block_stream_parser_core_macros.svh"
module tx_block_stream_parser_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,      // parse_mode
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,       // [7:0] byte_in, [31:8] bytes_after
  input  logic         in_tuser,       // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata       // field_tag, byte_out, field_end, field_value,
                                       // tx_number, entry_number, status (low first),
                                       // zero fill above bit 128
);

  tbsp_pkg::item_t   item;
  tbsp_pkg::result_t res, q0_r, q1_r;
  logic mode_r, step, v0_r, v1_r;

  assign item.byte_in     = in_tdata[7:0];
  assign item.bytes_after = in_tdata[31:8];
  assign item.first_byte  = in_tuser;

  // two-entry output queue: q0 is the head, q1 the skid slot
  assign in_tready = !v1_r;
  assign step      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  tbsp_seq #(.LENGTH_BITS(LENGTH_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .step(step), .mode(mode_r), .item(item), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      priority if (!v0_r || (out_tready && !v1_r)) begin
        v0_r <= step;
      end else if (out_tready) begin
        v0_r <= 1'b1; v1_r <= step;
      end else begin
        v1_r <= v1_r || step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!v0_r || (out_tready && !v1_r)) q0_r <= res;
    else if (out_tready) begin
      q0_r <= q1_r; q1_r <= res;
    end else if (!v1_r) q1_r <= res;
  end

  assign out_tvalid = v0_r;
  assign out_tdata  = {7'd0, q0_r.status, q0_r.entry_number, q0_r.tx_number,
                       q0_r.field_value, q0_r.field_end, q0_r.byte_out, q0_r.field_tag};

  `TBSP_ASSERT(a_no_overflow, clk, rst_n, (v1_r && !out_tready) |-> !step)
  `TBSP_ASSERT(a_skid_order, clk, rst_n, v1_r |-> v0_r)
  `TBSP_ASSERT(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid)

endmodule

// ===== sv/tbsp_field.sv =====
// Field assembly: byte counting, little-endian value build and varint decode.
// Depends on tbsp_pkg.
module tbsp_field #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        restart,
  input  logic [4:0]  tag,
  input  logic [7:0]  byte_in,
  input  logic [LENGTH_BITS-1:0] scr_left,
  output logic        done,
  output logic [63:0] value
);

  logic [6:0]  bif_r, bif_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vlen_r, vlen_nxt;
  logic [6:0]  bif;
  logic [63:0] acc;
  tbsp_pkg::kind_t kind;
  logic [5:0]  len;
  logic [63:0] sh;

  assign kind = tbsp_pkg::field_kind(tag);
  assign len  = tbsp_pkg::field_len(tag);

  // a restarting byte sees a cleared field
  assign bif = restart ? '0 : bif_r;
  assign acc = restart ? '0 : acc_r;

  always_comb begin
    bif_nxt  = bif;
    acc_nxt  = acc;
    vlen_nxt = vlen_r;
    done     = 1'b0;
    value    = '0;
    sh       = '0;
    unique case (kind)
      tbsp_pkg::KIND_FIX: begin
        if (len <= 6'd8 && bif < 7'd8)
          sh = {56'd0, byte_in} << {bif[2:0], 3'b000};
        if ({1'b0, bif} + 8'd1 >= {2'b00, len}) begin
          done = 1'b1;
          value = (len <= 6'd8) ? (acc | sh) : '0;
          bif_nxt = '0;
          acc_nxt = '0;
        end else begin
          acc_nxt = acc | sh;
          bif_nxt = bif + 7'd1;
        end
      end
      tbsp_pkg::KIND_VAR: begin
        if (bif == '0) begin
          if (byte_in < 8'd253) begin
            done = 1'b1;
            value = {56'd0, byte_in};
          end else begin
            vlen_nxt = (byte_in == 8'd253) ? 4'd2 : ((byte_in == 8'd254) ? 4'd4 : 4'd8);
            acc_nxt = '0;
            bif_nxt = 7'd1;
          end
        end else begin
          if (bif <= 7'd8) begin
            sh = {56'd0, byte_in} << {bif[2:0] - 3'd1, 3'b000};
          end
          if (bif >= {3'd0, vlen_r}) begin
            done = 1'b1;
            value = acc | sh;
            bif_nxt = '0;
            acc_nxt = '0;
            vlen_nxt = '0;
          end else begin
            acc_nxt = acc | sh;
            bif_nxt = bif + 7'd1;
          end
        end
      end
      default: begin
        done = (scr_left == LENGTH_BITS'(1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bif_r  <= '0;
      acc_r  <= '0;
      vlen_r <= '0;
    end else if (step) begin
      bif_r  <= bif_nxt;
      acc_r  <= acc_nxt;
      vlen_r <= vlen_nxt;
    end
  end

endmodule

// ===== sv/tbsp_seq.sv =====
// Structure sequencer: phase, counts, indexes and structural checks.
// Depends on tbsp_pkg and tbsp_field; includes the assertion macros.
`include "tx_block_stream_parser_core_macros.svh"
module tbsp_seq #(
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              mode,
  input  tbsp_pkg::item_t   item,
  output tbsp_pkg::result_t res
);

  localparam logic [LENGTH_BITS-1:0] LMAX = '1;

  logic [4:0]  phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] scr_r, scr_nxt, ent_left_r, ent_left_nxt, txs_r, txs_nxt;
  logic        halted_r, halted_nxt, blk_r, blk_nxt;
  logic [23:0] txi_r, txi_nxt, enti_r, enti_nxt;

  logic [4:0]  ph;
  logic        hl, blk, fdone, wide, ba0;
  logic [23:0] enti, txi;
  logic [LENGTH_BITS-1:0] scr_in, sat;
  logic [63:0] fval;
  logic [2:0]  st;
  logic [23:0] ba;
  logic [29:0] ba41, ba9, ba10;

  // restart view of the current state
  assign ph   = item.first_byte ? (mode ? tbsp_pkg::TAG_VERSION : tbsp_pkg::TAG_TXVERSION)
                                : phase_r;
  assign hl   = item.first_byte ? 1'b0 : halted_r;
  assign blk  = item.first_byte ? mode : blk_r;
  assign enti = item.first_byte ? '0 : enti_r;
  assign txi  = item.first_byte ? '0 : txi_r;
  assign scr_in = item.first_byte ? '0 : scr_r;
  assign ba   = item.bytes_after;
  assign ba0  = (ba == '0);

  tbsp_field #(.LENGTH_BITS(LENGTH_BITS)) u_field (
    .clk(clk), .rst_n(rst_n), .step(step && !hl && ph != tbsp_pkg::TAG_IDLE),
    .restart(step && item.first_byte), .tag(ph), .byte_in(item.byte_in),
    .scr_left(scr_in), .done(fdone), .value(fval)
  );

  assign wide = (fval >= {{(64-LENGTH_BITS){1'b0}}, LMAX});
  assign sat  = wide ? LMAX : fval[LENGTH_BITS-1:0];
  // v > floor(ba/k) holds exactly when v*k > ba, so no divider is needed
  assign ba41 = 30'(ba);
  assign ba9  = 30'(ba);
  assign ba10 = 30'(ba);

  function automatic logic over(input logic [LENGTH_BITS-1:0] v, input logic [29:0] b,
                                input logic [5:0] k);
    logic [LENGTH_BITS+5:0] p;
    begin
      p = (LENGTH_BITS+6)'(v) * (LENGTH_BITS+6)'(k);
      over = (LENGTH_BITS+7)'(p) > (LENGTH_BITS+7)'(b);
    end
  endfunction

  always_comb begin
    phase_nxt    = ph;
    halted_nxt   = hl;
    blk_nxt      = blk;
    txi_nxt      = txi;
    enti_nxt     = enti;
    scr_nxt      = scr_in;
    ent_left_nxt = item.first_byte ? '0 : ent_left_r;
    txs_nxt      = item.first_byte ? '0 : txs_r;
    st           = tbsp_pkg::ST_PARSING;
    res          = '0;
    if (hl || ph == tbsp_pkg::TAG_IDLE) begin
      res.field_tag = tbsp_pkg::TAG_IDLE;
      res.status    = tbsp_pkg::ST_IGNORED;
    end else begin
      if (ph == tbsp_pkg::TAG_INSCRIPT || ph == tbsp_pkg::TAG_OUTSCRIPT)
        scr_nxt = scr_in - LENGTH_BITS'(1);
      if (fdone) begin
        unique case (ph)
          tbsp_pkg::TAG_TXCOUNT: begin
            if (wide || over(sat, ba10, 6'd10)) begin
              st = tbsp_pkg::ST_COUNT_BIG; halted_nxt = 1'b1;
            end else begin
              txs_nxt = sat; txi_nxt = '0;
              if (sat == '0) begin
                st = ba0 ? tbsp_pkg::ST_DONE : tbsp_pkg::ST_TRAIL; halted_nxt = 1'b1;
              end else phase_nxt = tbsp_pkg::TAG_TXVERSION;
            end
          end
          tbsp_pkg::TAG_INCOUNT, tbsp_pkg::TAG_OUTCOUNT: begin
            if (wide || over(sat, (ph == tbsp_pkg::TAG_INCOUNT) ? ba41 : ba9,
                             (ph == tbsp_pkg::TAG_INCOUNT) ? 6'd41 : 6'd9)) begin
              st = tbsp_pkg::ST_COUNT_BIG; halted_nxt = 1'b1;
            end else begin
              ent_left_nxt = sat; enti_nxt = '0;
              if (ph == tbsp_pkg::TAG_INCOUNT)
                phase_nxt = (sat == '0) ? tbsp_pkg::TAG_OUTCOUNT : tbsp_pkg::TAG_PREVHASH;
              else
                phase_nxt = (sat == '0) ? tbsp_pkg::TAG_LOCKTIME : tbsp_pkg::TAG_OUTVALUE;
            end
          end
          tbsp_pkg::TAG_INSCRLEN, tbsp_pkg::TAG_OUTSCRLEN: begin
            if (wide || (32'(sat) > 32'(ba))) begin
              st = tbsp_pkg::ST_SCRIPT; halted_nxt = 1'b1;
            end else begin
              scr_nxt = sat;
              if (sat != '0) phase_nxt = ph + 5'd1;
              else if (ph == tbsp_pkg::TAG_INSCRLEN) phase_nxt = tbsp_pkg::TAG_SEQUENCE;
              else begin
                ent_left_nxt = ent_left_r - LENGTH_BITS'(1);
                if (ent_left_nxt == '0) begin
                  enti_nxt = '0; phase_nxt = tbsp_pkg::TAG_LOCKTIME;
                end else begin
                  enti_nxt = enti + 24'd1; phase_nxt = tbsp_pkg::TAG_OUTVALUE;
                end
              end
            end
          end
          tbsp_pkg::TAG_SEQUENCE, tbsp_pkg::TAG_OUTSCRIPT: begin
            ent_left_nxt = ent_left_r - LENGTH_BITS'(1);
            if (ent_left_nxt == '0) begin
              enti_nxt = '0;
              phase_nxt = (ph == tbsp_pkg::TAG_SEQUENCE) ? tbsp_pkg::TAG_OUTCOUNT
                                                         : tbsp_pkg::TAG_LOCKTIME;
            end else begin
              enti_nxt = enti + 24'd1;
              phase_nxt = (ph == tbsp_pkg::TAG_SEQUENCE) ? tbsp_pkg::TAG_PREVHASH
                                                         : tbsp_pkg::TAG_OUTVALUE;
            end
          end
          tbsp_pkg::TAG_LOCKTIME: begin
            if (!blk) begin
              st = tbsp_pkg::ST_DONE; halted_nxt = 1'b1;
            end else begin
              txs_nxt = txs_r - LENGTH_BITS'(1);
              txi_nxt = txi + 24'd1;
              if (txs_nxt == '0) begin
                st = ba0 ? tbsp_pkg::ST_DONE : tbsp_pkg::ST_TRAIL; halted_nxt = 1'b1;
              end else phase_nxt = tbsp_pkg::TAG_TXVERSION;
            end
          end
          default: phase_nxt = ph + 5'd1;
        endcase
      end
      if (!halted_nxt && ba0) begin
        st = tbsp_pkg::ST_TRUNC; halted_nxt = 1'b1;
      end
      res.field_tag    = ph;
      res.byte_out     = item.byte_in;
      res.field_end    = fdone;
      res.field_value  = fdone ? fval : '0;
      res.tx_number    = (blk && ph >= tbsp_pkg::TAG_TXVERSION) ? txi : '0;
      res.entry_number = ((ph >= tbsp_pkg::TAG_PREVHASH && ph <= tbsp_pkg::TAG_SEQUENCE) ||
                          (ph >= tbsp_pkg::TAG_OUTVALUE && ph <= tbsp_pkg::TAG_OUTSCRIPT))
                         ? enti : '0;
      res.status       = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tbsp_pkg::TAG_IDLE;
      halted_r <= 1'b0; blk_r <= 1'b0;
      txi_r <= '0; enti_r <= '0; scr_r <= '0; ent_left_r <= '0; txs_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; halted_r <= halted_nxt; blk_r <= blk_nxt;
      txi_r <= txi_nxt; enti_r <= enti_nxt; scr_r <= scr_nxt;
      ent_left_r <= ent_left_nxt; txs_r <= txs_nxt;
    end
  end

  `TBSP_ASSERT(a_halt_on_final, clk, rst_n, (step && res.status != tbsp_pkg::ST_PARSING && res.status != tbsp_pkg::ST_IGNORED) |=> halted_r)
  `TBSP_ASSERT(a_ign_tag, clk, rst_n, (res.status == tbsp_pkg::ST_IGNORED) |-> (res.field_tag == tbsp_pkg::TAG_IDLE))
  `TBSP_ASSERT(a_phase_range, clk, rst_n, phase_r <= tbsp_pkg::TAG_IDLE)

endmodule
